// ===== design/mcur_pkg.sv =====
// shared types, constants and control structs of the ultrasonic ranger
package mcur_pkg;

  // channel count and derived widths
  localparam int CHANNELS = 3;
  localparam int CH_W     = 2;
  localparam int ECHO_W   = 3;
  localparam int TICK_W   = 16;
  localparam int PER_W    = 17;
  localparam int DIVR_W   = 8;
  localparam int DIST_W   = 17;
  localparam int DIV_W    = 17;
  localparam int DCNT_W   = 5;

  localparam logic [ECHO_W-1:0] CHAN_MASK = ECHO_W'((1 << CHANNELS) - 1);

  // register indexes
  localparam logic [1:0] REG_PERIOD    = 2'd0;
  localparam logic [1:0] REG_DIVISOR   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // register reset values and limits
  localparam logic [PER_W-1:0]  PERIOD_RESET    = 17'd3125;
  localparam logic [DIVR_W-1:0] DIVISOR_RESET   = 8'd29;
  localparam logic [DIST_W-1:0] THRESHOLD_RESET = 17'd1;
  localparam logic [PER_W-1:0]  PERIOD_MIN      = 17'd2;
  localparam logic [PER_W-1:0]  PERIOD_MAX      = 17'd65536;

  // capture phase of the armed channel
  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_WAIT_RISE,
    PHASE_WAIT_FALL
  } phase_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MOD_TICK,
    ST_MOD_START,
    ST_SUB,
    ST_DIVIDE,
    ST_WRITE
  } state_t;

  // divider operand select
  typedef enum logic [1:0] {
    DIV_TICK,
    DIV_START,
    DIV_DIST
  } div_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_tick;
    logic     take_start;
    logic     take_width;
    logic     take_dist;
    logic     write;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done_pend;
    logic tick_ge_p;
    logic start_ge_p;
    logic div_done;
    logic out_free;
  } status_t;

  // input word
  typedef struct packed {
    logic [ECHO_W-1:0] echo_levels;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [ECHO_W-1:0] trigger_pulse;
    logic [ECHO_W-1:0] led_state;
    logic              measure_done;
    logic [CH_W-1:0]   measure_channel;
    logic [TICK_W-1:0] pulse_width;
    logic [DIST_W-1:0] distance;
  } out_word_t;

endpackage

// ===== design/mcur_stream_if.sv =====
// valid/ready stream interface carrying one word
interface mcur_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mcur_divider.sv =====
// restoring divider, one quotient bit per cycle
module mcur_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mcur_pkg::DIV_W-1:0] dividend,
  input  logic [mcur_pkg::DIV_W-1:0] divisor,
  output logic [mcur_pkg::DIV_W-1:0] quotient,
  output logic [mcur_pkg::DIV_W-1:0] remainder,
  output logic                       done
);

  logic                        busy;
  logic [mcur_pkg::DCNT_W-1:0] cnt;
  logic [mcur_pkg::DIV_W-1:0]  den;
  logic [mcur_pkg::DIV_W:0]    shifted;
  logic                        fits;

  // trial subtract of the shifted remainder
  always_comb begin
    shifted = {remainder, quotient[mcur_pkg::DIV_W-1]};
    fits    = shifted >= {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= mcur_pkg::DCNT_W'(mcur_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == mcur_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      den       <= divisor;
    end else if (busy) begin
      remainder <= fits ? mcur_pkg::DIV_W'(shifted - {1'b0, den})
                        : shifted[mcur_pkg::DIV_W-1:0];
      quotient  <= {quotient[mcur_pkg::DIV_W-2:0], fits};
    end
  end

endmodule

// ===== design/mcur_ctrl.sv =====
// controller state machine sequencing one tick through the datapath
module mcur_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mcur_pkg::status_t status,
  output mcur_pkg::cmd_t    cmd
);

  mcur_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcur_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.div_sel = mcur_pkg::DIV_TICK;
    case (state)
      mcur_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mcur_pkg::ST_EVAL;
        end
      end
      mcur_pkg::ST_EVAL: begin
        if (!status.done_pend) begin
          state_next = mcur_pkg::ST_WRITE;
        end else if (status.tick_ge_p) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = mcur_pkg::DIV_TICK;
          state_next    = mcur_pkg::ST_MOD_TICK;
        end else if (status.start_ge_p) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = mcur_pkg::DIV_START;
          state_next    = mcur_pkg::ST_MOD_START;
        end else begin
          state_next = mcur_pkg::ST_SUB;
        end
      end
      mcur_pkg::ST_MOD_TICK: begin
        if (status.div_done) begin
          cmd.take_tick = 1'b1;
          if (status.start_ge_p) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = mcur_pkg::DIV_START;
            state_next    = mcur_pkg::ST_MOD_START;
          end else begin
            state_next = mcur_pkg::ST_SUB;
          end
        end
      end
      mcur_pkg::ST_MOD_START: begin
        if (status.div_done) begin
          cmd.take_start = 1'b1;
          state_next     = mcur_pkg::ST_SUB;
        end
      end
      mcur_pkg::ST_SUB: begin
        cmd.take_width = 1'b1;
        cmd.div_start  = 1'b1;
        cmd.div_sel    = mcur_pkg::DIV_DIST;
        state_next     = mcur_pkg::ST_DIVIDE;
      end
      mcur_pkg::ST_DIVIDE: begin
        if (status.div_done) begin
          cmd.take_dist = 1'b1;
          state_next    = mcur_pkg::ST_WRITE;
        end
      end
      mcur_pkg::ST_WRITE: begin
        if (status.out_free) begin
          cmd.write  = 1'b1;
          state_next = mcur_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mcur_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/mcur_datapath.sv =====
// datapath: registers, tick counter, edge capture, width reduction and output word
module mcur_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  mcur_pkg::cmd_t               cmd,
  output mcur_pkg::status_t            status,
  input  mcur_pkg::in_word_t           in_word,
  output mcur_pkg::out_word_t          out_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [mcur_pkg::PER_W-1:0]   cfg_data
);

  // configuration registers
  logic [mcur_pkg::PER_W-1:0]  period_ticks;
  logic [mcur_pkg::DIVR_W-1:0] divisor_half_ticks;
  logic [mcur_pkg::DIST_W-1:0] near_threshold;

  // tick state
  logic [mcur_pkg::TICK_W-1:0] tick_count;
  logic [mcur_pkg::CH_W-1:0]   slot_index;
  mcur_pkg::phase_t            capture_phase;
  logic [mcur_pkg::CH_W-1:0]   armed_channel;
  logic [mcur_pkg::TICK_W-1:0] start_count;
  logic [mcur_pkg::ECHO_W-1:0] previous_echo;
  logic [mcur_pkg::ECHO_W-1:0] indicator_bits;

  // per tick work registers
  logic                        done_pend;
  logic [mcur_pkg::ECHO_W-1:0] trig_r;
  logic [mcur_pkg::CH_W-1:0]   mch_r;
  logic [mcur_pkg::TICK_W-1:0] red_tick;
  logic [mcur_pkg::TICK_W-1:0] red_start;
  logic [mcur_pkg::TICK_W-1:0] width_r;
  logic [mcur_pkg::DIST_W-1:0] dist_r;

  logic [mcur_pkg::PER_W-1:0]  p_eff;
  logic [mcur_pkg::PER_W-1:0]  div_eff;
  logic [mcur_pkg::ECHO_W-1:0] echo;
  logic                        was, now, armed_ok, rise, fall, wrap;
  logic [mcur_pkg::PER_W-1:0]  width_full;
  logic [mcur_pkg::ECHO_W-1:0] mch_bit;
  logic [mcur_pkg::ECHO_W-1:0] led_next;

  logic [mcur_pkg::DIV_W-1:0]  dvd, dvs, quo, rem;
  logic                        div_done;

  // effective period and divisor
  always_comb begin
    if (period_ticks < mcur_pkg::PERIOD_MIN) begin
      p_eff = mcur_pkg::PERIOD_MIN;
    end else if (period_ticks > mcur_pkg::PERIOD_MAX) begin
      p_eff = mcur_pkg::PERIOD_MAX;
    end else begin
      p_eff = period_ticks;
    end
    div_eff = (divisor_half_ticks == '0) ? mcur_pkg::PER_W'(1)
                                         : mcur_pkg::PER_W'(divisor_half_ticks);
  end

  // edge detection on the armed echo line
  always_comb begin
    echo     = in_word.echo_levels & mcur_pkg::CHAN_MASK;
    armed_ok = (capture_phase != mcur_pkg::PHASE_IDLE) &&
               (32'(armed_channel) < mcur_pkg::CHANNELS);
    was      = previous_echo[armed_channel];
    now      = echo[armed_channel];
    rise     = armed_ok && (capture_phase == mcur_pkg::PHASE_WAIT_RISE) && !was && now;
    fall     = armed_ok && (capture_phase == mcur_pkg::PHASE_WAIT_FALL) && was && !now;
    wrap     = {1'b0, tick_count} >= (p_eff - 1'b1);
  end

  // width modulo period from the reduced counts
  always_comb begin
    if (red_tick >= red_start) begin
      width_full = {1'b0, red_tick} - {1'b0, red_start};
    end else begin
      width_full = {1'b0, red_tick} + p_eff - {1'b0, red_start};
    end
  end

  // indicator update at the end of a measurement
  always_comb begin
    mch_bit  = mcur_pkg::ECHO_W'(1) << mch_r;
    led_next = indicator_bits;
    if (done_pend) begin
      if (dist_r >= near_threshold) begin
        led_next = indicator_bits | mch_bit;
      end else begin
        led_next = indicator_bits & ~mch_bit;
      end
    end
  end

  // divider operands
  always_comb begin
    case (cmd.div_sel)
      mcur_pkg::DIV_TICK: begin
        dvd = mcur_pkg::DIV_W'(red_tick);
        dvs = p_eff;
      end
      mcur_pkg::DIV_START: begin
        dvd = mcur_pkg::DIV_W'(red_start);
        dvs = p_eff;
      end
      mcur_pkg::DIV_DIST: begin
        dvd = {width_full[mcur_pkg::TICK_W-1:0], 1'b0};
        dvs = div_eff;
      end
      default: begin
        dvd = '0;
        dvs = div_eff;
      end
    endcase
  end

  mcur_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  // status to the controller
  always_comb begin
    status.done_pend  = done_pend;
    status.tick_ge_p  = {1'b0, red_tick} >= p_eff;
    status.start_ge_p = {1'b0, red_start} >= p_eff;
    status.div_done   = div_done;
    status.out_free   = !out_valid || out_ready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks       <= mcur_pkg::PERIOD_RESET;
      divisor_half_ticks <= mcur_pkg::DIVISOR_RESET;
      near_threshold     <= mcur_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mcur_pkg::REG_PERIOD:    period_ticks       <= cfg_data;
        mcur_pkg::REG_DIVISOR:   divisor_half_ticks <= cfg_data[mcur_pkg::DIVR_W-1:0];
        mcur_pkg::REG_THRESHOLD: near_threshold     <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick state: capture, counter, round robin
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      slot_index     <= '0;
      capture_phase  <= mcur_pkg::PHASE_IDLE;
      armed_channel  <= '0;
      start_count    <= '0;
      previous_echo  <= '0;
      indicator_bits <= '0;
      done_pend      <= 1'b0;
    end else begin
      if (cmd.load) begin
        done_pend <= fall;
        if (rise) begin
          start_count <= tick_count;
        end
        // a trigger slot rearms and wins over an edge of the same tick
        if (wrap && (32'(slot_index) < mcur_pkg::CHANNELS)) begin
          armed_channel <= slot_index;
          capture_phase <= mcur_pkg::PHASE_WAIT_RISE;
        end else if (rise) begin
          capture_phase <= mcur_pkg::PHASE_WAIT_FALL;
        end else if (fall) begin
          capture_phase <= mcur_pkg::PHASE_IDLE;
        end
        if (wrap) begin
          tick_count <= '0;
          slot_index <= (32'(slot_index) >= mcur_pkg::CHANNELS) ? '0 : slot_index + 1'b1;
        end else begin
          tick_count <= tick_count + 1'b1;
        end
        previous_echo <= echo;
      end
      if (cmd.write) begin
        indicator_bits <= led_next;
      end
    end
  end

  // work registers of the current tick
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      trig_r    <= (wrap && (32'(slot_index) < mcur_pkg::CHANNELS))
                   ? (mcur_pkg::ECHO_W'(1) << slot_index) : '0;
      mch_r     <= armed_channel;
      red_tick  <= tick_count;
      red_start <= start_count;
    end
    if (cmd.take_tick) begin
      red_tick <= rem[mcur_pkg::TICK_W-1:0];
    end
    if (cmd.take_start) begin
      red_start <= rem[mcur_pkg::TICK_W-1:0];
    end
    if (cmd.take_width) begin
      width_r <= width_full[mcur_pkg::TICK_W-1:0];
    end
    if (cmd.take_dist) begin
      dist_r <= quo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      out_word.trigger_pulse   <= trig_r;
      out_word.led_state       <= led_next;
      out_word.measure_done    <= done_pend;
      out_word.measure_channel <= done_pend ? mch_r : '0;
      out_word.pulse_width     <= done_pend ? width_r : '0;
      out_word.distance        <= done_pend ? dist_r : '0;
    end
  end

endmodule

// ===== design/multi_channel_ultrasonic_ranger_unit.sv =====
// top level of the three channel ultrasonic echo ranger
// Each input word is one prescaled timer tick with the three echo levels; each tick gives
// exactly one output word with the trigger drive, the indicator bits and, when a falling
// echo edge ended a measurement, the channel, the pulse width modulo the period and the
// distance floor(2*width/divisor). The controller takes one tick at a time. A tick with no
// finished measurement steps through accept, evaluate and write. A finished measurement
// runs the shared 17-bit restoring divider once for the distance, and up to two more
// times before that to reduce the counts modulo the period after the period was made
// shorter. The output register lets the next tick be accepted while a word waits; a
// stalled output holds the controller in its write step. Registers: index 0 period_ticks,
// 1 divisor_half_ticks, 2 near_threshold.
module multi_channel_ultrasonic_ranger_unit (
  input  logic                       clk,
  input  logic                       rst,
  mcur_stream_if.sink                ticks,
  mcur_stream_if.source              results,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mcur_pkg::PER_W-1:0] cfg_data
);

  mcur_pkg::cmd_t    cmd;
  mcur_pkg::status_t status;
  logic              in_ready;

  assign ticks.ready = in_ready;

  // sequencing
  mcur_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ticks.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  mcur_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_word   (ticks.data),
    .out_word  (results.data),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

`ifndef SYNTHESIS
  // one tick at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    ticks.valid && ticks.ready |=> !ticks.ready)
    else $error("tick accepted while previous tick still in work");

  // at most one trigger per word
  a_trig_onehot: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> $onehot0(results.data.trigger_pulse))
    else $error("more than one trigger in one word");

  // idle measurement fields are zero
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.data.measure_done |->
      results.data.pulse_width == '0 && results.data.distance == '0 &&
      results.data.measure_channel == '0)
    else $error("measurement fields set without a finished measurement");

  // finished measurement names a real channel
  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.measure_done |->
      32'(results.data.measure_channel) < mcur_pkg::CHANNELS)
    else $error("measurement channel out of range");
`endif

endmodule

// ===== tb/mcur_range_check.sv =====
`timescale 1ns / 100ps
// scoreboard for the ultrasonic ranger: predicts every output word and compares it on exit
module mcur_range_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       tick_valid,
  input  logic                       tick_ready,
  input  mcur_pkg::in_word_t         tick_word,
  input  logic                       word_valid,
  input  logic                       word_ready,
  input  mcur_pkg::out_word_t        word_out,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mcur_pkg::PER_W-1:0] cfg_data,
  output int                         failures,
  output int                         outstanding,
  output int                         measured
);

  // shadow copies of the three registers
  logic [mcur_pkg::PER_W-1:0]  per_reg;
  logic [mcur_pkg::DIVR_W-1:0] div_reg;
  logic [mcur_pkg::DIST_W-1:0] thr_reg;

  // shadow ranging state
  logic [mcur_pkg::TICK_W-1:0] cnt_ticks;
  logic [mcur_pkg::TICK_W-1:0] rise_at;
  logic [1:0]                  slot;
  logic [mcur_pkg::CH_W-1:0]   armed;
  mcur_pkg::phase_t            phase;
  logic [mcur_pkg::ECHO_W-1:0] echo_prev;
  logic [mcur_pkg::ECHO_W-1:0] leds;

  // predicted words still waiting for the block
  mcur_pkg::out_word_t ranging_due [$];
  int                  n_in;
  int                  n_out;

  assign outstanding = n_in - n_out;

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    failures++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // advance the shadow ranger by one timer tick and build its output word
  function automatic mcur_pkg::out_word_t range_one_tick(
    input logic [mcur_pkg::ECHO_W-1:0] echo_raw);
    logic [mcur_pkg::ECHO_W-1:0] echo;
    int unsigned                 pi;
    int unsigned                 divi;
    int unsigned                 wi;
    int unsigned                 di;
    mcur_pkg::out_word_t         o;
    echo = echo_raw & mcur_pkg::CHAN_MASK;
    o    = '0;
    // out of range periods clamp to the legal span
    if (per_reg < mcur_pkg::PERIOD_MIN) begin
      pi = mcur_pkg::PERIOD_MIN;
    end else if (per_reg > mcur_pkg::PERIOD_MAX) begin
      pi = mcur_pkg::PERIOD_MAX;
    end else begin
      pi = per_reg;
    end
    // edge detection on the armed line uses the count before it moves
    if (phase != mcur_pkg::PHASE_IDLE && armed < mcur_pkg::CHANNELS) begin
      if (phase == mcur_pkg::PHASE_WAIT_RISE && !echo_prev[armed] && echo[armed]) begin
        rise_at = cnt_ticks;
        phase   = mcur_pkg::PHASE_WAIT_FALL;
      end else if (phase == mcur_pkg::PHASE_WAIT_FALL && echo_prev[armed] &&
                   !echo[armed]) begin
        divi = (div_reg == '0) ? 1 : div_reg;
        wi   = ((cnt_ticks % pi) + pi - (rise_at % pi)) % pi;
        di   = (2 * wi) / divi;
        o.measure_done    = 1'b1;
        o.measure_channel = armed;
        o.pulse_width     = mcur_pkg::TICK_W'(wi);
        o.distance        = mcur_pkg::DIST_W'(di);
        phase             = mcur_pkg::PHASE_IDLE;
        leds[armed]       = (di >= thr_reg);
      end
    end
    // counter wrap steps the round robin; trigger slots rearm capture
    if (cnt_ticks >= pi - 1) begin
      cnt_ticks = '0;
      if (slot < mcur_pkg::CHANNELS) begin
        o.trigger_pulse = mcur_pkg::ECHO_W'(1 << slot);
        armed           = mcur_pkg::CH_W'(slot);
        phase           = mcur_pkg::PHASE_WAIT_RISE;
      end
      slot = (slot >= mcur_pkg::CHANNELS) ? 2'd0 : slot + 2'd1;
    end else begin
      cnt_ticks = cnt_ticks + 1'b1;
    end
    echo_prev   = echo;
    o.led_state = leds;
    return o;
  endfunction

  // watch config writes, outgoing words and incoming ticks in that order
  always @(posedge clk) begin
    mcur_pkg::out_word_t want;
    if (rst) begin
      per_reg   = mcur_pkg::PERIOD_RESET;
      div_reg   = mcur_pkg::DIVISOR_RESET;
      thr_reg   = mcur_pkg::THRESHOLD_RESET;
      cnt_ticks = '0;
      rise_at   = '0;
      slot      = '0;
      armed     = '0;
      phase     = mcur_pkg::PHASE_IDLE;
      echo_prev = '0;
      leds      = '0;
      ranging_due.delete();
      n_in     <= 0;
      n_out    <= 0;
      measured <= 0;
    end else begin
      // register write
      if (cfg_we) begin
        case (cfg_index)
          mcur_pkg::REG_PERIOD:    per_reg = cfg_data;
          mcur_pkg::REG_DIVISOR:   div_reg = cfg_data[mcur_pkg::DIVR_W-1:0];
          mcur_pkg::REG_THRESHOLD: thr_reg = cfg_data;
          default: ;
        endcase
      end
      // result word against the oldest prediction
      if (word_valid && word_ready) begin
        n_out <= n_out + 1;
        if (ranging_due.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing due", n_out));
        end else begin
          want = ranging_due.pop_front();
          if (want.measure_done) begin
            measured <= measured + 1;
          end
          if (word_out.trigger_pulse !== want.trigger_pulse) begin
            report_mismatch($sformatf("word %0d trigger_pulse %0d, want %0d",
                                      n_out, word_out.trigger_pulse, want.trigger_pulse));
          end
          if (word_out.led_state !== want.led_state) begin
            report_mismatch($sformatf("word %0d led_state %0d, want %0d",
                                      n_out, word_out.led_state, want.led_state));
          end
          if (word_out.measure_done !== want.measure_done) begin
            report_mismatch($sformatf("word %0d measure_done %0d, want %0d",
                                      n_out, word_out.measure_done, want.measure_done));
          end
          if (word_out.measure_channel !== want.measure_channel) begin
            report_mismatch($sformatf("word %0d measure_channel %0d, want %0d",
                                      n_out, word_out.measure_channel, want.measure_channel));
          end
          if (word_out.pulse_width !== want.pulse_width) begin
            report_mismatch($sformatf("word %0d pulse_width %0d, want %0d",
                                      n_out, word_out.pulse_width, want.pulse_width));
          end
          if (word_out.distance !== want.distance) begin
            report_mismatch($sformatf("word %0d distance %0d, want %0d",
                                      n_out, word_out.distance, want.distance));
          end
        end
      end
      // incoming tick word
      if (tick_valid && tick_ready) begin
        ranging_due.push_back(range_one_tick(tick_word.echo_levels));
        n_in <= n_in + 1;
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench top for the ultrasonic ranger: clock, reset, tick stimulus and verdict
module tb;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          PHASES       = 8;
  localparam int          PHASE_TICKS  = 225;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic [1:0]                 cfg_index;
  logic [mcur_pkg::PER_W-1:0] cfg_data;
  logic                       calm;

  int          failures;
  int          outstanding;
  int          measured;
  int unsigned cycles;
  int          ticks_sent;
  int          reg_writes;
  int unsigned cur_period;
  int          ready_hold;

  // echo responder: triggers seen on the output and pulses scheduled per channel
  int unsigned trig_seen [mcur_pkg::CHANNELS];
  int unsigned trig_used [mcur_pkg::CHANNELS];
  int unsigned echo_lag  [mcur_pkg::CHANNELS];
  int unsigned echo_hold [mcur_pkg::CHANNELS];

  mcur_stream_if #(.word_t(mcur_pkg::in_word_t))  ticks_ch ();
  mcur_stream_if #(.word_t(mcur_pkg::out_word_t)) results_ch ();

  multi_channel_ultrasonic_ranger_unit dut (
    .clk       (clk),
    .rst       (rst),
    .ticks     (ticks_ch),
    .results   (results_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mcur_range_check range_check (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (ticks_ch.valid),
    .tick_ready  (ticks_ch.ready),
    .tick_word   (ticks_ch.data),
    .word_valid  (results_ch.valid),
    .word_ready  (results_ch.ready),
    .word_out    (results_ch.data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding),
    .measured    (measured)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back pressure
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
      ready_hold       <= 0;
    end else if (calm) begin
      results_ch.ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (results_ch.ready) begin
      if ($urandom_range(0, 3) == 0) begin
        results_ch.ready <= 1'b0;
        ready_hold       <= pick_gap();
      end
    end else begin
      results_ch.ready <= 1'b1;
      ready_hold       <= $urandom_range(0, 12);
    end
  end

  // count trigger pulses leaving the block so the responder can answer them
  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) begin
      for (int ch = 0; ch < mcur_pkg::CHANNELS; ch++) begin
        if (results_ch.data.trigger_pulse[ch]) begin
          trig_seen[ch] <= trig_seen[ch] + 1;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

  // send one tick word, with a random gap ahead of it
  task automatic send_tick(input logic [mcur_pkg::ECHO_W-1:0] echo);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      ticks_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ticks_ch.valid <= 1'b1;
    ticks_ch.data  <= mcur_pkg::in_word_t'(echo);
    @(posedge clk);
    while (!ticks_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // hold the sender until every predicted word has left the block
  task automatic wait_drained();
    ticks_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // register write, only with the block drained
  task automatic write_reg(input logic [1:0] idx,
                           input logic [mcur_pkg::PER_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    if (idx == mcur_pkg::REG_PERIOD) begin
      cur_period = (value < mcur_pkg::PERIOD_MIN) ? mcur_pkg::PERIOD_MIN :
                   (value > mcur_pkg::PERIOD_MAX) ? mcur_pkg::PERIOD_MAX : value;
    end
  endtask

  // echo levels that answer each trigger with a delayed pulse, plus some noise
  function automatic logic [mcur_pkg::ECHO_W-1:0] shaped_echo();
    logic [mcur_pkg::ECHO_W-1:0] e;
    int unsigned                 span;
    int                          k;
    span = (cur_period > 48) ? 48 : cur_period;
    for (int ch = 0; ch < mcur_pkg::CHANNELS; ch++) begin
      if (trig_used[ch] != trig_seen[ch]) begin
        trig_used[ch] = trig_seen[ch];
        // now and then a trigger gets no answer
        if ($urandom_range(0, 9) != 0) begin
          echo_lag[ch]  = $urandom_range(0, span / 2);
          echo_hold[ch] = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 2 * span : span);
        end
      end
      e[ch] = (echo_lag[ch] == 0 && echo_hold[ch] != 0);
      if (echo_lag[ch] != 0) begin
        echo_lag[ch]--;
      end else if (echo_hold[ch] != 0) begin
        echo_hold[ch]--;
      end
    end
    // glitches and fully random levels
    if ($urandom_range(0, 19) == 0) begin
      k    = $urandom_range(0, mcur_pkg::CHANNELS - 1);
      e[k] = ~e[k];
    end
    if ($urandom_range(0, 49) == 0) begin
      e = mcur_pkg::ECHO_W'($urandom);
    end
    return e;
  endfunction

  // stimulus
  initial begin
    int          ph;
    int          n;
    int unsigned per;
    int unsigned dv;
    int unsigned dmax;
    int unsigned thr;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = mcur_pkg::REG_PERIOD;
    cfg_data         = '0;
    calm             = 1'b0;
    ticks_ch.valid   = 1'b0;
    ticks_ch.data    = '0;
    results_ch.ready = 1'b0;
    cycles           = 0;
    ticks_sent       = 0;
    reg_writes       = 0;
    cur_period       = mcur_pkg::PERIOD_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // a few ticks at the reset settings
    send_tick(3'b111);
    send_tick(3'b000);
    send_tick(3'b101);
    send_tick(3'b010);

    // shortest period: the count already sits past the end and wraps at once
    write_reg(mcur_pkg::REG_PERIOD, 17'd2);
    send_tick(3'b000);
    // channel 0 rises, then stays high while the next slot rearms on channel 1
    send_tick(3'b001);
    send_tick(3'b001);
    // channel 1 full pulse, distance below the threshold
    send_tick(3'b010);
    send_tick(3'b000);
    // channel 2 rises late in its slot, and falls in the idle slot that follows
    send_tick(3'b000);
    send_tick(3'b100);
    // widest period and unit divisor: stale start gives the widest pulse
    write_reg(mcur_pkg::REG_PERIOD, 17'h10000);
    write_reg(mcur_pkg::REG_DIVISOR, 17'd1);
    write_reg(mcur_pkg::REG_THRESHOLD, 17'd131070);
    send_tick(3'b000);

    // period above the top clamps, then period zero acts as two
    write_reg(mcur_pkg::REG_THRESHOLD, 17'h1FFFF);
    write_reg(mcur_pkg::REG_PERIOD, 17'h1FFFF);
    write_reg(mcur_pkg::REG_PERIOD, 17'd0);
    send_tick(3'b000);
    send_tick(3'b001);
    send_tick(3'b000);

    // zero threshold, zero divisor, period one
    write_reg(mcur_pkg::REG_THRESHOLD, 17'd0);
    write_reg(mcur_pkg::REG_DIVISOR, 17'd0);
    write_reg(mcur_pkg::REG_PERIOD, 17'd1);
    send_tick(3'b010);
    send_tick(3'b010);
    send_tick(3'b110);
    send_tick(3'b011);
    send_tick(3'b000);

    // divisor data above its width, and a write to an unused index
    write_reg(mcur_pkg::REG_DIVISOR, 17'h10003);
    write_reg(REG_UNUSED, 17'h1FFFF);
    send_tick(3'b111);
    send_tick(3'b000);

    // random phases with echoes that answer the triggers
    for (ph = 0; ph < PHASES; ph++) begin
      calm = 1'b0;
      if (ph == PHASES - 1) begin
        write_reg(mcur_pkg::REG_PERIOD, mcur_pkg::PER_W'($urandom));
        write_reg(mcur_pkg::REG_DIVISOR, mcur_pkg::PER_W'($urandom));
        write_reg(mcur_pkg::REG_THRESHOLD, mcur_pkg::PER_W'($urandom));
      end
      case (ph)
        2:       per = 1;
        5:       per = 0;
        6:       per = $urandom_range(40, 120);
        default: per = $urandom_range(2, 24);
      endcase
      case (ph)
        0:       dv = 1;
        1:       dv = 255;
        3:       dv = 0;
        default: dv = $urandom_range(1, 9);
      endcase
      write_reg(mcur_pkg::REG_PERIOD, mcur_pkg::PER_W'(per));
      write_reg(mcur_pkg::REG_DIVISOR, mcur_pkg::PER_W'(dv));
      dmax = (2 * cur_period) / ((dv == 0) ? 1 : dv);
      case (ph)
        1:       thr = 17'h1FFFF;
        4:       thr = 0;
        default: thr = $urandom_range(0, dmax + 1);
      endcase
      write_reg(mcur_pkg::REG_THRESHOLD, mcur_pkg::PER_W'(thr));
      // one phase runs with no idling on either side
      calm = (ph == 3);
      for (n = 0; n < PHASE_TICKS; n++) begin
        if ($urandom_range(0, 199) == 0) begin
          wait_drained();
        end
        send_tick(shaped_echo());
      end
    end

    // drain and let any stray word show up
    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d ticks sent across %0d register writes", ticks_sent, reg_writes);
    $display("%0d echo measurements finished and checked", measured);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
